FILE: hdl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// Page table manager package
// Shared widths, codes, payload structs and a helper function for the
// two-level page table manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

   localparam int FRAME_W  = 20;
   localparam int VPAGE_W  = 20;
   localparam int KPL_W    = 21;
   localparam int UPC_W    = 21;
   localparam int FFC_W    = 13;
   localparam int FLAG_W   = 3;
   localparam int ENTRY_W  = 32;
   localparam int OP_W     = 3;

   localparam int VIRT_PAGE_BITS_DEF    = 20;
   localparam int ENTRIES_PER_TABLE_DEF = 1024;
   localparam int FREE_STACK_DEPTH_DEF  = 4096;

   localparam logic [KPL_W-1:0] KPL_RESET = 21'd262144;
   localparam logic [UPC_W-1:0] USER_MAX  = {UPC_W{1'b1}};

   // Page entry layout.
   localparam int ENT_PRESENT_BIT  = 0;
   localparam int ENT_WRITABLE_BIT = 1;
   localparam int ENT_USER_BIT     = 2;
   localparam int ENT_SOFT_LSB     = 9;
   localparam int ENT_FRAME_LSB    = 12;

   // Directory word layout: live count above these control bits.
   localparam int DIR_USER_BIT    = 20;
   localparam int DIR_PRESENT_BIT = 21;
   localparam int DIR_CTL_W       = 22;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 88;

   typedef enum logic [OP_W-1:0] {
      OP_TRANSLATE = 3'd0,
      OP_MAP       = 3'd1,
      OP_UNMAP     = 3'd2,
      OP_SET_FLAGS = 3'd3,
      OP_GET_FLAGS = 3'd4,
      OP_PUSH      = 3'd5,
      OP_POP       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO     = 2'd1,
      ST_NO_TABLE = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [FLAG_W-1:0]  flag_bits;
      logic               allow_alloc;
      logic               user_mode;
      logic [FRAME_W-1:0] phys_page;
      logic [VPAGE_W-1:0] virt_page;
   } req_type;

   typedef struct packed {
      logic [FFC_W-1:0]   free_frame_count;
      logic [UPC_W-1:0]   user_page_count;
      logic [FRAME_W-1:0] released_table_frame;
      logic               table_released;
      status_type         status;
      logic [FLAG_W-1:0]  flags_out;
      logic               present;
      logic [FRAME_W-1:0] frame_out;
   } rsp_type;

   // Write strobes from the operation unit to the memories and sequencer.
   typedef struct packed {
      logic dir_we;
      logic ent_we;
      logic stk_we;
      logic new_table;
   } wr_ctl_type;

   function automatic int addr_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tpm_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = tpm_pkg::addr_w(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/tpm_op_unit.sv
// ----------------------------------------------------------------------------
// Page table operation unit
// Decodes one item against the directory word, page entry and stack top
// that were read for it, and produces the write-back values and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_op_unit #(
   parameter int VIRT_PAGE_BITS    = tpm_pkg::VIRT_PAGE_BITS_DEF,
   parameter int ENTRIES_PER_TABLE = tpm_pkg::ENTRIES_PER_TABLE_DEF,
   parameter int FREE_STACK_DEPTH  = tpm_pkg::FREE_STACK_DEPTH_DEF,
   parameter int DIR_W             = $clog2(ENTRIES_PER_TABLE + 1) + tpm_pkg::DIR_CTL_W,
   parameter int SD_W              = $clog2(FREE_STACK_DEPTH + 1)
) (
   input  tpm_pkg::op_type                   op,
   input  tpm_pkg::req_type                  req,
   input  logic [DIR_W-1:0]                  dir_rd,
   input  logic [tpm_pkg::ENTRY_W-1:0]       ent_rd,
   input  logic [tpm_pkg::FRAME_W-1:0]       stk_rd,
   input  logic [SD_W-1:0]                   depth,
   input  logic [tpm_pkg::UPC_W-1:0]         user_pages,
   input  logic [tpm_pkg::KPL_W-1:0]         kpl,
   output tpm_pkg::wr_ctl_type               ctl,
   output logic [DIR_W-1:0]                  dir_wd,
   output logic [tpm_pkg::ENTRY_W-1:0]       ent_wd,
   output logic [tpm_pkg::FRAME_W-1:0]       stk_wd,
   output logic [SD_W-1:0]                   depth_upd,
   output logic [tpm_pkg::UPC_W-1:0]         user_upd,
   output tpm_pkg::rsp_type                  rsp
);

   import tpm_pkg::*;

   localparam int TS   = $clog2(ENTRIES_PER_TABLE);
   localparam int LC_W = DIR_W - DIR_CTL_W;

   logic [VIRT_PAGE_BITS-1:0] vp;
   logic [KPL_W-1:0]          ti_ext;
   logic [KPL_W-1:0]          kpl_table;
   logic [KPL_W-1:0]          vp_ext;
   logic                      has_table;
   logic [FRAME_W-1:0]        dir_frame;
   logic [LC_W-1:0]           live;
   logic [LC_W-1:0]           live_up;
   logic [LC_W-1:0]           live_dn;
   logic                      stack_full;
   logic                      stack_empty;
   logic [ENTRY_W-1:0]        map_entry;
   logic [UPC_W-1:0]          user_map;
   logic [SD_W+FFC_W-1:0]     depth_wide;

   assign vp          = req.virt_page[VIRT_PAGE_BITS-1:0];
   assign ti_ext      = KPL_W'(vp >> TS);
   assign kpl_table   = kpl >> TS;
   assign vp_ext      = KPL_W'(vp);
   assign has_table   = dir_rd[DIR_PRESENT_BIT];
   assign dir_frame   = dir_rd[FRAME_W-1:0];
   assign live        = dir_rd[DIR_W-1:DIR_CTL_W];
   assign live_up     = live + 1'b1;
   assign live_dn     = (ent_rd != '0 && live != '0) ? live - 1'b1 : live;
   assign stack_full  = (depth == SD_W'(FREE_STACK_DEPTH));
   assign stack_empty = (depth == '0);
   // Frame, no software flags, user bit from the mode, writable and present.
   assign map_entry   = {req.phys_page, 9'd0, req.user_mode, 1'b1, 1'b1};
   assign user_map    = (req.user_mode && user_pages != USER_MAX) ?
                        user_pages + 1'b1 : user_pages;

   always_comb begin
      ctl        = '0;
      dir_wd     = dir_rd;
      ent_wd     = map_entry;
      stk_wd     = req.phys_page;
      depth_upd  = depth;
      user_upd   = user_pages;
      rsp        = '0;
      rsp.status = ST_OK;

      case (op)
         OP_TRANSLATE: begin
            if (!has_table) begin
               rsp.status = ST_NO_TABLE;
            end else if (ent_rd[ENT_PRESENT_BIT]) begin
               rsp.frame_out = ent_rd[ENTRY_W-1:ENT_FRAME_LSB];
               rsp.present   = 1'b1;
            end
         end
         OP_MAP: begin
            if (vp == '0 || req.phys_page == '0) begin
               rsp.status = ST_ZERO;
            end else if (!has_table) begin
               if (!req.allow_alloc) begin
                  rsp.status = ST_NO_TABLE;
               end else if (stack_empty) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  // The new table holds just this entry once it is zeroed.
                  depth_upd     = depth - 1'b1;
                  dir_wd        = {LC_W'(1), 1'b1, (ti_ext >= kpl_table), stk_rd};
                  ctl.dir_we    = 1'b1;
                  ctl.new_table = 1'b1;
                  user_upd      = user_map;
               end
            end else begin
               dir_wd     = {((ent_rd == '0) ? live_up : live), dir_rd[DIR_CTL_W-1:0]};
               ctl.dir_we = 1'b1;
               ctl.ent_we = 1'b1;
               user_upd   = user_map;
            end
         end
         OP_UNMAP: begin
            if (!has_table) begin
               rsp.status = ST_NO_TABLE;
            end else begin
               rsp.frame_out = ent_rd[ENTRY_W-1:ENT_FRAME_LSB];
               ent_wd        = '0;
               ctl.ent_we    = 1'b1;
               ctl.dir_we    = 1'b1;
               if (live_dn == '0) begin
                  rsp.table_released       = 1'b1;
                  rsp.released_table_frame = dir_frame;
                  dir_wd                   = '0;
                  if (stack_full) begin
                     rsp.status = ST_EMPTY;
                  end else begin
                     ctl.stk_we = 1'b1;
                     stk_wd     = dir_frame;
                     depth_upd  = depth + 1'b1;
                  end
               end else begin
                  dir_wd = {live_dn, dir_rd[DIR_CTL_W-1:0]};
               end
               if (vp_ext >= kpl && user_pages != '0) begin
                  user_upd = user_pages - 1'b1;
               end
            end
         end
         OP_SET_FLAGS: begin
            if (!has_table) begin
               rsp.status = ST_NO_TABLE;
            end else begin
               ent_wd     = ent_rd | {{(ENTRY_W-ENT_SOFT_LSB-FLAG_W){1'b0}},
                                      req.flag_bits, {ENT_SOFT_LSB{1'b0}}};
               ctl.ent_we = 1'b1;
               dir_wd     = {((ent_rd == '0 && req.flag_bits != '0) ? live_up : live),
                             dir_rd[DIR_CTL_W-1:0]};
               ctl.dir_we = 1'b1;
            end
         end
         OP_GET_FLAGS: begin
            if (!has_table) begin
               rsp.status = ST_NO_TABLE;
            end else begin
               rsp.flags_out = ent_rd[ENT_SOFT_LSB+FLAG_W-1:ENT_SOFT_LSB];
            end
         end
         OP_PUSH: begin
            if (req.phys_page == '0) begin
               rsp.status = ST_ZERO;
            end else if (stack_full) begin
               rsp.status = ST_EMPTY;
            end else begin
               ctl.stk_we = 1'b1;
               depth_upd  = depth + 1'b1;
            end
         end
         OP_POP: begin
            if (stack_empty) begin
               rsp.status = ST_EMPTY;
            end else begin
               depth_upd     = depth - 1'b1;
               rsp.frame_out = stk_rd;
            end
         end
         default: begin
         end
      endcase

      rsp.user_page_count  = user_upd;
      rsp.free_frame_count = depth_wide[FFC_W-1:0];
   end

   assign depth_wide = {{FFC_W{1'b0}}, depth_upd};

endmodule

`default_nettype wire

FILE: hdl/two_level_page_table_manager_unit.sv
// ----------------------------------------------------------------------------
// Two-level page table manager
// An item is accepted in the idle state, and its memory reads are issued on
// the accept edge. In the execute state the result is registered, and the
// memory writes happen, once the output register is free. No new item is
// taken until the block is back in idle; a map that creates a table first
// runs a zeroing sweep over the ENTRIES_PER_TABLE entries of the new table.
// Reset (synchronous, active high) clears all 2**VIRT_PAGE_BITS /
// ENTRIES_PER_TABLE directory words in a pass during which no item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_manager_unit #(
   parameter int VIRT_PAGE_BITS    = tpm_pkg::VIRT_PAGE_BITS_DEF,
   parameter int ENTRIES_PER_TABLE = tpm_pkg::ENTRIES_PER_TABLE_DEF,
   parameter int FREE_STACK_DEPTH  = tpm_pkg::FREE_STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration: kernel_page_limit.
   input  logic                               csr_wr_en,
   input  logic [tpm_pkg::KPL_W-1:0]          csr_wr_data,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: virt_page, phys_page, user_mode, allow_alloc, flag_bits, zero pad.
   input  logic [tpm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: op.
   input  logic [tpm_pkg::OP_W-1:0]           req_tuser,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: frame_out, present, flags_out, status, table_released,
   // released_table_frame, user_page_count, free_frame_count, zero pad.
   output logic [tpm_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import tpm_pkg::*;

   // Tables are power-of-two sized, so table index and offset are bit fields
   // of the virtual page, and a page-entry address is just the page number.
   localparam int TS         = $clog2(ENTRIES_PER_TABLE);
   localparam int NUM_TABLES = 2 ** (VIRT_PAGE_BITS - TS);
   localparam int NUM_PAGES  = 2 ** VIRT_PAGE_BITS;
   localparam int DIR_AW     = addr_w(NUM_TABLES);
   localparam int LC_W       = $clog2(ENTRIES_PER_TABLE + 1);
   localparam int DIR_W      = LC_W + DIR_CTL_W;
   localparam int SA_W       = addr_w(FREE_STACK_DEPTH);
   localparam int SD_W       = $clog2(FREE_STACK_DEPTH + 1);
   localparam logic [VIRT_PAGE_BITS-1:0] OFFSET_MASK = VIRT_PAGE_BITS'(ENTRIES_PER_TABLE - 1);

   // INIT clears the directory after reset, EXEC evaluates one item against
   // the memory words read on its accept edge, CLEAR zeroes a new table.
   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_CLEAR
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   op_type              op_ff, op_in;
   logic [KPL_W-1:0]    kpl_ff, kpl_in;
   logic [SD_W-1:0]     depth_ff, depth_in;
   logic [UPC_W-1:0]    user_ff, user_in;
   logic [DIR_AW-1:0]   init_idx_ff, init_idx_in;
   logic [TS-1:0]       clr_idx_ff, clr_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   req_type                   req_word;
   logic                      req_accept;
   logic                      out_free;
   logic                      do_exec;
   logic [VIRT_PAGE_BITS-1:0] vp_new;
   logic [VIRT_PAGE_BITS-1:0] vp_cur;
   logic [DIR_AW-1:0]         ti_new;
   logic [DIR_AW-1:0]         ti_cur;
   logic [VIRT_PAGE_BITS-1:0] clr_addr;
   logic                      clr_hit;
   logic                      clr_last;
   logic                      init_last;

   wr_ctl_type           ctl;
   logic [DIR_W-1:0]     dir_rd, dir_wd;
   logic [ENTRY_W-1:0]   ent_rd, ent_wd;
   logic [FRAME_W-1:0]   stk_rd, stk_wd;
   logic [SD_W-1:0]      op_depth;
   logic [UPC_W-1:0]     op_user;
   rsp_type              op_rsp;

   logic                 dir_we;
   logic [DIR_AW-1:0]    dir_waddr;
   logic [DIR_W-1:0]     dir_wdata;
   logic                 ent_we;
   logic [VIRT_PAGE_BITS-1:0] ent_waddr;
   logic [ENTRY_W-1:0]   ent_wdata;
   logic                 stk_we;

   assign req_word   = req_type'(req_tdata[$bits(req_type)-1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // The output register frees up in the same cycle that its item is taken.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign do_exec  = (state_ff == S_EXEC) && out_free;

   assign vp_new = req_word.virt_page[VIRT_PAGE_BITS-1:0];
   assign vp_cur = req_ff.virt_page[VIRT_PAGE_BITS-1:0];
   assign ti_new = DIR_AW'(vp_new >> TS);
   assign ti_cur = DIR_AW'(vp_cur >> TS);

   // Zeroing sweep over the table of the current page; the mapped entry is
   // written in place of zero when the sweep passes its offset.
   assign clr_addr  = (vp_cur & ~OFFSET_MASK) | VIRT_PAGE_BITS'(clr_idx_ff);
   assign clr_hit   = (clr_idx_ff == vp_cur[TS-1:0]);
   assign clr_last  = (clr_idx_ff == TS'(ENTRIES_PER_TABLE - 1));
   assign init_last = (init_idx_ff == DIR_AW'(NUM_TABLES - 1));

   // All memory reads are issued on the accept edge. Every write of the
   // previous item lands before the block returns to idle, so a read never
   // overlaps a pending write to the same entry.
   assign dir_we    = (state_ff == S_INIT) || (do_exec && ctl.dir_we);
   assign dir_waddr = (state_ff == S_INIT) ? init_idx_ff : ti_cur;
   assign dir_wdata = (state_ff == S_INIT) ? '0 : dir_wd;

   assign ent_we    = (state_ff == S_CLEAR) || (do_exec && ctl.ent_we);
   assign ent_waddr = (state_ff == S_CLEAR) ? clr_addr : vp_cur;
   assign ent_wdata = (state_ff == S_CLEAR && !clr_hit) ? '0 : ent_wd;

   assign stk_we = do_exec && ctl.stk_we;

   tpm_ram #(
      .WIDTH (DIR_W),
      .DEPTH (NUM_TABLES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (req_accept),
      .rd_addr (ti_new),
      .rd_data (dir_rd)
   );

   tpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_PAGES)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (req_accept),
      .rd_addr (vp_new),
      .rd_data (ent_rd)
   );

   // Free-frame stack: the top entry is read ahead so a pop or a table
   // allocation has it in the execute cycle.
   tpm_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (FREE_STACK_DEPTH)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (SA_W'(depth_ff)),
      .wr_data (stk_wd),
      .rd_en   (req_accept),
      .rd_addr (SA_W'(depth_ff - 1'b1)),
      .rd_data (stk_rd)
   );

   tpm_op_unit #(
      .VIRT_PAGE_BITS    (VIRT_PAGE_BITS),
      .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
      .FREE_STACK_DEPTH  (FREE_STACK_DEPTH),
      .DIR_W             (DIR_W),
      .SD_W              (SD_W)
   ) u_op_unit (
      .op         (op_ff),
      .req        (req_ff),
      .dir_rd     (dir_rd),
      .ent_rd     (ent_rd),
      .stk_rd     (stk_rd),
      .depth      (depth_ff),
      .user_pages (user_ff),
      .kpl        (kpl_ff),
      .ctl        (ctl),
      .dir_wd     (dir_wd),
      .ent_wd     (ent_wd),
      .stk_wd     (stk_wd),
      .depth_upd  (op_depth),
      .user_upd   (op_user),
      .rsp        (op_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      op_in        = op_ff;
      kpl_in       = csr_wr_en ? csr_wr_data : kpl_ff;
      depth_in     = depth_ff;
      user_in      = user_ff;
      init_idx_in  = init_idx_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_INIT: begin
            init_idx_in = init_idx_ff + 1'b1;
            if (init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               req_in   = req_word;
               op_in    = op_type'(req_tuser);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // The result goes out now even when a table sweep follows: the
            // next item is not accepted until the sweep is over.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = op_rsp;
               depth_in     = op_depth;
               user_in      = op_user;
               clr_idx_in   = '0;
               state_in     = ctl.new_table ? S_CLEAR : S_IDLE;
            end
         end
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         kpl_ff       <= KPL_RESET;
         depth_ff     <= '0;
         user_ff      <= '0;
         init_idx_ff  <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kpl_ff       <= kpl_in;
         depth_ff     <= depth_in;
         user_ff      <= user_in;
         init_idx_ff  <= init_idx_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SD_W'(FREE_STACK_DEPTH))
      else $error("free stack depth beyond its capacity");

   assert property (@(posedge clock) disable iff (reset)
      !do_exec |=> $stable(depth_ff))
      else $error("free stack depth moved outside an executed item");

   assert property (@(posedge clock) disable iff (reset)
      !do_exec |=> $stable(user_ff))
      else $error("user page count moved outside an executed item");

   assert property (@(posedge clock) disable iff (reset)
      (do_exec && ctl.new_table) |-> (op_ff == OP_MAP && depth_ff != '0))
      else $error("table created by an item other than a map with a free frame");

   assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_CLEAR) |-> (clr_idx_ff == '0 && rsp_valid_ff))
      else $error("table sweep did not start at entry zero after its result");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Page table manager testbench
// Drives translate, map, unmap, flag and free-stack items into the two-level
// page table manager and checks every result, field by field, against a
// predictor that keeps its own directory, entry store and free-frame stack.
// Directed items come first. Mixed traffic then runs under several kernel
// boundary settings, followed by a long receiver hold-off and a fill of the
// free stack to its limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tpm_pkg::*;

   // Geometry of the block at its default parameters.
   localparam int NUM_TABLES = (1 << VIRT_PAGE_BITS_DEF) / ENTRIES_PER_TABLE_DEF;
   localparam int EPT        = ENTRIES_PER_TABLE_DEF;
   localparam int FSD        = FREE_STACK_DEPTH_DEF;
   localparam int REQ_W      = $bits(req_type);
   localparam int RSP_W      = $bits(rsp_type);
   localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

   // The op field is three bits wide, so code 7 can be sent; it does nothing.
   localparam logic [OP_W-1:0] OP_NOP = 3'd7;

   // Length of a requested receiver hold-off, in clock cycles.
   localparam int RSP_HOLD_CYCLES = 300;

   // Watchdog. The slowest legal run is dominated by table-zeroing sweeps
   // (one per map that creates a table) and by the free-stack fill; this is
   // several times that.
   localparam longint LIMIT_NS = 64'd6_000_000;

   // ------------------------------------------------------------------------
   // Clock, reset and the block's inputs, all known from time zero.
   // ------------------------------------------------------------------------
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [KPL_W-1:0]       csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [OP_W-1:0]        req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   two_level_page_table_manager_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of everything the block keeps.
   // ------------------------------------------------------------------------
   bit               dir_present [NUM_TABLES];
   bit [FRAME_W-1:0] dir_frame   [NUM_TABLES];
   int unsigned      live_cnt    [NUM_TABLES];
   // Page entries are sparse; a missing key reads as a zero entry.
   bit [ENTRY_W-1:0] entry_store [int unsigned];
   bit [FRAME_W-1:0] frame_stack [FSD];
   int unsigned      stack_top    = 0;
   int unsigned      user_cnt     = 0;
   logic [KPL_W-1:0] kernel_limit = KPL_RESET;

   // Results that the block owes us, oldest first.
   rsp_type          queued_page_results [$];

   int unsigned      items_sent     = 0;
   int unsigned      rsp_seen       = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      tables_built   = 0;
   int unsigned      tables_freed   = 0;
   int unsigned      hold_requests  = 0;
   int unsigned      hold_served    = 0;

   // Sender bookkeeping: items left in the current burst, and whether
   // req_tvalid was left high by the last accepted item.
   int               burst_left = 0;
   bit               valid_up   = 1'b0;

   // Pushes one frame onto the predicted free stack; a full stack drops it.
   function automatic bit stack_push_frame(input bit [FRAME_W-1:0] frame);
      if (stack_top >= FSD) return 1'b0;
      frame_stack[stack_top] = frame;
      stack_top++;
      return 1'b1;
   endfunction

   // Applies one operation to the predicted state and returns the result
   // the block must produce for it.
   function automatic rsp_type compute_page_op(input logic [OP_W-1:0] op,
                                               input req_type rq);
      rsp_type          r;
      bit [ENTRY_W-1:0] ent;
      int unsigned      vp;
      int unsigned      ti;
      int unsigned      base;
      bit               has_tab;
      bit               ok;
      r       = '0;
      vp      = rq.virt_page;
      ti      = vp / EPT;
      has_tab = dir_present[ti];
      ent     = entry_store.exists(vp) ? entry_store[vp] : '0;
      case (op)
         OP_TRANSLATE: begin
            if (!has_tab) begin
               r.status = ST_NO_TABLE;
            end else if (ent[ENT_PRESENT_BIT]) begin
               r.frame_out = ent[ENTRY_W-1:ENT_FRAME_LSB];
               r.present   = 1'b1;
            end
         end
         OP_MAP: begin
            if (rq.virt_page == '0 || rq.phys_page == '0) begin
               r.status = ST_ZERO;
            end else begin
               ok = 1'b1;
               if (!has_tab) begin
                  if (!rq.allow_alloc) begin
                     r.status = ST_NO_TABLE;
                     ok = 1'b0;
                  end else if (stack_top == 0) begin
                     r.status = ST_EMPTY;
                     ok = 1'b0;
                  end else begin
                     // A new table takes the top free frame and starts empty.
                     stack_top--;
                     dir_frame[ti]   = frame_stack[stack_top];
                     dir_present[ti] = 1'b1;
                     base = ti * EPT;
                     for (int i = 0; i < EPT; i++) entry_store.delete(base + i);
                     live_cnt[ti] = 0;
                     ent = '0;
                     tables_built++;
                  end
               end
               if (ok) begin
                  if (ent == '0) live_cnt[ti]++;
                  // The whole entry is rewritten, so software flags go away.
                  ent = '0;
                  ent[ENTRY_W-1:ENT_FRAME_LSB] = rq.phys_page;
                  ent[ENT_PRESENT_BIT]  = 1'b1;
                  ent[ENT_WRITABLE_BIT] = 1'b1;
                  ent[ENT_USER_BIT]     = rq.user_mode;
                  entry_store[vp] = ent;
                  if (rq.user_mode && user_cnt < USER_MAX) user_cnt++;
               end
            end
         end
         OP_UNMAP: begin
            if (!has_tab) begin
               r.status = ST_NO_TABLE;
            end else begin
               // The frame bits come back even when the page is not present.
               r.frame_out = ent[ENTRY_W-1:ENT_FRAME_LSB];
               if (ent != '0 && live_cnt[ti] > 0) live_cnt[ti]--;
               entry_store.delete(vp);
               if (live_cnt[ti] == 0) begin
                  // The table is empty: it is released and its frame pushed if the stack has room.
                  r.table_released       = 1'b1;
                  r.released_table_frame = dir_frame[ti];
                  dir_present[ti] = 1'b0;
                  tables_freed++;
                  if (!stack_push_frame(dir_frame[ti])) r.status = ST_EMPTY;
               end
               if (vp >= kernel_limit && user_cnt > 0) user_cnt--;
            end
         end
         OP_SET_FLAGS: begin
            if (!has_tab) begin
               r.status = ST_NO_TABLE;
            end else begin
               // Flags on an empty entry make it count as live.
               if (ent == '0 && rq.flag_bits != '0) live_cnt[ti]++;
               ent[ENT_SOFT_LSB +: FLAG_W] = ent[ENT_SOFT_LSB +: FLAG_W] | rq.flag_bits;
               entry_store[vp] = ent;
            end
         end
         OP_GET_FLAGS: begin
            if (!has_tab) r.status = ST_NO_TABLE;
            else r.flags_out = ent[ENT_SOFT_LSB +: FLAG_W];
         end
         OP_PUSH: begin
            if (rq.phys_page == '0) r.status = ST_ZERO;
            else if (!stack_push_frame(rq.phys_page)) r.status = ST_EMPTY;
         end
         OP_POP: begin
            if (stack_top == 0) begin
               r.status = ST_EMPTY;
            end else begin
               stack_top--;
               r.frame_out = frame_stack[stack_top];
            end
         end
         default: begin
         end
      endcase
      r.user_page_count  = user_cnt[UPC_W-1:0];
      r.free_frame_count = stack_top[FFC_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Every wait between items in the test tasks goes through idle_cycles or
   // wait_drained, which first take back a valid left high by the last item,
   // so req_tvalid sees only one assignment per time step.
   // ------------------------------------------------------------------------
   task automatic drop_valid();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic idle_cycles(input int n);
      drop_valid();
      repeat (n) @(posedge clock);
   endtask

   // The sender pauses until every owed result has come back.
   task automatic wait_drained();
      drop_valid();
      while (queued_page_results.size() != 0) @(posedge clock);
   endtask

   // Offers one item and waits for its handshake. The item's expected
   // result is worked out at the accepting edge, so the predictor state is
   // always current for whoever picks the next item.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [VPAGE_W-1:0] vp,
                            input logic [FRAME_W-1:0] pp, input bit user,
                            input bit alloc, input logic [FLAG_W-1:0] fl);
      req_type fields;
      int      gap;
      fields.virt_page   = vp;
      fields.phys_page   = pp;
      fields.user_mode   = user;
      fields.allow_alloc = alloc;
      fields.flag_bits   = fl;
      if (burst_left == 0) begin
         // A new burst; most bursts are preceded by a gap of random length.
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) idle_cycles(gap);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_W){1'b0}}, fields};
      req_tuser  <= op;
      valid_up = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      queued_page_results.push_back(compute_page_op(op, fields));
      items_sent++;
   endtask

   // Registers are written only while nothing is in flight.
   task automatic write_kernel_limit(input logic [KPL_W-1:0] value);
      wait_drained();
      idle_cycles(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      kernel_limit = value;
   endtask

   // ------------------------------------------------------------------------
   // Random item helpers.
   // ------------------------------------------------------------------------
   function automatic logic [FRAME_W-1:0] rnd_frame();
      return $urandom_range(0, FRAME_MAX);
   endfunction

   function automatic logic [FRAME_W-1:0] rnd_nonzero_frame();
      return $urandom_range(1, FRAME_MAX);
   endfunction

   // Pages are drawn mostly from a few tables and a few offsets so that
   // maps, lookups and unmaps meet the same entries; the rest spread out
   // over the whole space and the kernel boundary.
   function automatic logic [VPAGE_W-1:0] pick_virt_page();
      int unsigned ti;
      int unsigned off;
      int unsigned kl_page;
      kl_page = (kernel_limit > FRAME_MAX) ? FRAME_MAX : kernel_limit;
      case ($urandom_range(0, 11))
         0: ti = 0;
         1: ti = NUM_TABLES - 1;
         // Pages right at and right below the kernel boundary.
         2: return kl_page[VPAGE_W-1:0];
         3: return kl_page[VPAGE_W-1:0] - 1'b1;
         // The whole page number at random.
         4: return $urandom_range(0, FRAME_MAX);
         5: ti = $urandom_range(0, NUM_TABLES - 1);
         default: ti = 2 + 257 * $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 9))
         0: off = EPT - 1;
         1, 2: off = $urandom_range(0, EPT - 1);
         default: off = $urandom_range(0, 7);
      endcase
      return ti * EPT + off;
   endfunction

   // One item of any kind with random content; this is the noise.
   task automatic send_random_item();
      int               sel;
      logic [OP_W-1:0]  op;
      logic [FRAME_W-1:0] pp;
      sel = $urandom_range(0, 99);
      if (sel < 10)      op = OP_PUSH;
      else if (sel < 16) op = OP_POP;
      else if (sel < 40) op = OP_MAP;
      else if (sel < 54) op = OP_TRANSLATE;
      else if (sel < 70) op = OP_UNMAP;
      else if (sel < 83) op = OP_SET_FLAGS;
      else if (sel < 98) op = OP_GET_FLAGS;
      else               op = OP_NOP;
      pp = ($urandom_range(0, 31) == 0) ? '0 : rnd_nonzero_frame();
      send_item(op, pick_virt_page(), pp, $urandom_range(0, 1),
                $urandom_range(0, 7) != 0, $urandom_range(0, 7));
   endtask

   // A well-formed life of one page: map with a frame available, a few
   // lookups and flag updates, then usually an unmap.
   task automatic run_page_life_cycle();
      logic [VPAGE_W-1:0] vp;
      bit                 user;
      int                 n;
      vp   = pick_virt_page();
      user = $urandom_range(0, 1);
      if (stack_top == 0)
         send_item(OP_PUSH, rnd_frame(), rnd_nonzero_frame(), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 7));
      send_item(OP_MAP, vp, rnd_nonzero_frame(), user, 1'b1, $urandom_range(0, 7));
      n = $urandom_range(1, 4);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: send_item(OP_TRANSLATE, vp, rnd_frame(), user, 1'b1, $urandom_range(0, 7));
            1: send_item(OP_SET_FLAGS, vp, rnd_frame(), user, 1'b1, $urandom_range(0, 7));
            default: send_item(OP_GET_FLAGS, vp, rnd_frame(), user, 1'b0,
                               $urandom_range(0, 7));
         endcase
      end
      if ($urandom_range(0, 4) < 3)
         send_item(OP_UNMAP, vp, rnd_frame(), user, 1'b0, $urandom_range(0, 7));
   endtask

   task automatic run_mixed_traffic(input int n);
      int unsigned stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 4) run_page_life_cycle();
         else send_random_item();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Every operation, the field extremes and each corner case once, starting
   // from an empty free stack and an empty directory.
   task automatic test_directed_ops();
      send_item(OP_POP,       20'd5, 20'd0, 1'b0, 1'b0, 3'd0);     // empty stack
      send_item(OP_MAP,       20'd5, 20'd9, 1'b0, 1'b0, 3'd0);     // no table, no alloc
      send_item(OP_MAP,       20'd5, 20'd9, 1'b1, 1'b1, 3'd0);     // no frame for a table
      send_item(OP_TRANSLATE, 20'd5, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_UNMAP,     20'd5, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_SET_FLAGS, 20'd5, 20'd0, 1'b0, 1'b0, 3'd7);
      send_item(OP_GET_FLAGS, 20'd5, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_PUSH,      20'd0, 20'd0, 1'b0, 1'b0, 3'd0);     // frame zero ignored
      send_item(OP_PUSH,      20'd0, FRAME_MAX, 1'b1, 1'b1, 3'd7);
      send_item(OP_PUSH,      20'd0, 20'h5A5A5, 1'b0, 1'b0, 3'd0);
      send_item(OP_MAP,       20'd0, 20'd3, 1'b0, 1'b1, 3'd0);     // page zero
      send_item(OP_MAP,       20'h12345, 20'd0, 1'b0, 1'b1, 3'd0); // frame zero
      // Top page of the top table: creates a user table from 0x5A5A5.
      send_item(OP_MAP,       FRAME_MAX, FRAME_MAX, 1'b1, 1'b1, 3'd7);
      send_item(OP_TRANSLATE, FRAME_MAX, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_TRANSLATE, 20'hFFC00, 20'd0, 1'b0, 1'b0, 3'd0); // not present
      send_item(OP_SET_FLAGS, FRAME_MAX, 20'd0, 1'b0, 1'b0, 3'd7);
      send_item(OP_GET_FLAGS, FRAME_MAX, 20'd0, 1'b0, 1'b0, 3'd0);
      // A remap rewrites the entry, so the flags read back as zero.
      send_item(OP_MAP,       FRAME_MAX, 20'd1, 1'b0, 1'b0, 3'd0);
      send_item(OP_GET_FLAGS, FRAME_MAX, 20'd0, 1'b0, 1'b0, 3'd0);
      // Flags on an empty entry keep the table alive.
      send_item(OP_SET_FLAGS, 20'hFFC01, 20'd0, 1'b0, 1'b0, 3'd5);
      // Unmap of an entry that was never set; the user count hits zero.
      send_item(OP_UNMAP,     20'hFFC02, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_UNMAP,     FRAME_MAX, 20'd0, 1'b0, 1'b0, 3'd0);
      // The last live entry goes, so the table frame returns to the stack.
      send_item(OP_UNMAP,     20'hFFC01, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_NOP,       FRAME_MAX, FRAME_MAX, 1'b1, 1'b1, 3'd7);
      send_item(OP_POP,       20'd0, 20'd0, 1'b0, 1'b0, 3'd0);
      send_item(OP_POP,       20'd0, 20'd0, 1'b0, 1'b0, 3'd0);
   endtask

   // Mixed traffic under the reset boundary, both extremes and random ones.
   task automatic test_kernel_limit_sweep();
      logic [KPL_W-1:0] setting;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: setting = KPL_RESET;
            1: setting = '0;
            2: setting = 21'd1048576;
            default: setting = $urandom_range(1, 1048575);
         endcase
         write_kernel_limit(setting);
         run_mixed_traffic(240);
      end
   endtask

   // The receiver holds off while the sender keeps offering items, so the
   // block backs up and stalls its input.
   task automatic test_receiver_hold();
      wait_drained();
      hold_requests++;
      repeat (40) send_random_item();
   endtask

   // Fill the free stack, overflow it with a push and with a table release,
   // then pop it back down.
   task automatic test_stack_limits();
      int unsigned        ti;
      logic [VPAGE_W-1:0] vp;
      ti = NUM_TABLES / 2;
      while (dir_present[ti]) ti++;
      vp = ti * EPT + 1;
      if (stack_top == 0)
         send_item(OP_PUSH, '0, rnd_nonzero_frame(), 1'b0, 1'b0, '0);
      send_item(OP_MAP, vp, rnd_nonzero_frame(), 1'b0, 1'b1, '0);
      while (stack_top < FSD)
         send_item(OP_PUSH, rnd_frame(), rnd_nonzero_frame(), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 7));
      send_item(OP_PUSH, '0, rnd_nonzero_frame(), 1'b0, 1'b0, '0);
      // The release is reported although its frame cannot be pushed.
      send_item(OP_UNMAP, vp, '0, 1'b0, 1'b0, '0);
      while (stack_top > 8)
         send_item(OP_POP, rnd_frame(), rnd_frame(), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 7));
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready follows random patterns of random length, including
   // stretches of steady ready, and holds off on request.
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_pattern
      int mode;
      int run_len;
      forever begin
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(4, 40);
         repeat (run_len) begin
            @(posedge clock);
            if (hold_served != hold_requests) begin
               hold_served++;
               rsp_tready <= 1'b0;
               repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 1) == 1);
                  2: rsp_tready <= ($urandom_range(0, 3) != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checking against the oldest owed result.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_type'(rsp_tdata[RSP_W-1:0]);
         rsp_seen++;
         if (queued_page_results.size() == 0) begin
            $error("result item with no item outstanding: 0x%0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = queued_page_results.pop_front();
            check_field("frame_out", want.frame_out, got.frame_out);
            check_field("present", want.present, got.present);
            check_field("flags_out", want.flags_out, got.flags_out);
            check_field("status", want.status, got.status);
            check_field("table_released", want.table_released, got.table_released);
            check_field("released_table_frame", want.released_table_frame,
                        got.released_table_frame);
            check_field("user_page_count", want.user_page_count, got.user_page_count);
            check_field("free_frame_count", want.free_frame_count, got.free_frame_count);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence. The block runs a directory clearing pass after reset;
   // the first handshake simply waits it out.
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_kernel_limit_sweep();
      test_receiver_hold();
      test_stack_limits();
      wait_drained();
      // Stay idle so that a stray extra result would still be seen.
      idle_cycles(16);
      $display("Sent %0d items, checked %0d results; %0d tables built, %0d released.",
               items_sent, rsp_seen, tables_built, tables_freed);
      $display("Kernel boundary at reset, 0, 2^20 and random; %0d-cycle hold-off; stack filled to %0d.",
               RSP_HOLD_CYCLES, FSD);
      if (mismatch_count == 0 && queued_page_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("Timeout with %0d results outstanding.", queued_page_results.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
